// ===== src/pmv_pkg.sv =====
// Shared types and constants of the pose message validator.
package pmv_pkg;

  localparam int unsigned JointsDef     = 25;
  localparam int unsigned ValueCountDef = 200;

  localparam logic [31:0] MagicWord  = 32'h3152_4243;
  localparam int unsigned HeaderLen  = 40;
  localparam int unsigned JointBase  = 44;
  localparam int unsigned ShortLen   = 68;
  localparam logic [9:0]  CountMax   = 10'd1023;
  localparam logic [62:0] NormSat    = {63{1'b1}};
  localparam logic [62:0] NormLow    = 63'(64'd1 << 59);
  localparam logic [62:0] NormHigh   = 63'(64'd3 << 59);
  localparam logic [7:0]  ExpInf     = 8'hFF;

  localparam logic [2:0] StatusOk        = 3'd0;
  localparam logic [2:0] StatusTrunc     = 3'd1;
  localparam logic [2:0] StatusEnvelope  = 3'd2;
  localparam logic [2:0] StatusMask      = 3'd3;
  localparam logic [2:0] StatusUntracked = 3'd4;
  localparam logic [2:0] StatusBadXform  = 3'd5;

  // Header fields reported with a summary.
  typedef struct packed {
    logic [2:0]  pre_status;
    logic [7:0]  kind;
    logic        pvalid;
    logic [31:0] epoch;
    logic [31:0] space;
    logic [31:0] seq;
    logic [52:0] obs;
    logic [52:0] tgt;
    logic [24:0] mask;
  } sum_t;

  // One queue entry: an optional value with its joint checks, an optional summary.
  typedef struct packed {
    logic        val;
    logic [7:0]  idx;
    logic [31:0] bits;
    logic        sq;
    logic        jlast;
    logic        tracked;
    logic        chk;
    logic        stride8;
    logic        sum;
    sum_t        hdr;
  } entry_t;

  typedef struct packed {
    logic        is_sum;
    logic [7:0]  idx;
    logic [31:0] bits;
    logic [2:0]  status;
    logic [7:0]  kind;
    logic        pvalid;
    logic [31:0] epoch;
    logic [31:0] space;
    logic [31:0] seq;
    logic [52:0] obs;
    logic [52:0] tgt;
    logic [24:0] mask;
  } out_t;

endpackage

// ===== src/pmv_front.sv =====
// Byte parser: captures the header, assembles float values and builds queue entries.
module pmv_front import pmv_pkg::*; #(
  parameter int unsigned JOINTS      = JointsDef,
  parameter int unsigned VALUE_COUNT = ValueCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [24:0] allowed_i,
  output logic        push_o,
  output entry_t      entry_o
);

  // The joint counter must reach 32, one past the last possible joint.
  localparam int unsigned JW = 6;
  localparam logic [10:0] ValBytes = 11'(4 * VALUE_COUNT);
  localparam logic [10:0] LongLen  = 11'(JointBase + 4 * VALUE_COUNT);
  localparam logic [JW-1:0] JointsLim = JW'(JOINTS);

  logic [9:0]       cnt_q, cnt_d;
  logic [43:0][7:0] hdr_q, hdr_d;
  logic [31:0]      vsh_q, vsh_d;
  logic [2:0]       elem_q, elem_d;
  logic [JW-1:0]    joint_q, joint_d;

  logic        one, act, in_val, done, jlast, bad_env, mask_err;
  logic [10:0] off, limit, rel, expected;
  logic [31:0] magic, epoch, space, seq, len_w, mask_w, mask_s;
  logic [63:0] obs, tgt;
  logic [15:0] flag;
  logic [7:0]  ver, kind;
  logic [2:0]  pre;

  assign one = (hdr_q[5] == 8'd1);
  assign act = (cnt_q < CountMax);
  assign off = one ? 11'(HeaderLen) : 11'(JointBase);
  assign limit = one ? 11'd28 : ValBytes;
  assign rel = {1'b0, cnt_q} - off;
  assign in_val = act && ({1'b0, cnt_q} >= off) && (rel < limit);
  assign done = in_val && (rel[1:0] == 2'd3);
  assign jlast = one ? (elem_q == 3'd6) : (elem_q == 3'd7);

  always_comb begin
    cnt_d = cnt_q;
    hdr_d = hdr_q;
    vsh_d = vsh_q;
    elem_d = elem_q;
    joint_d = joint_q;
    if (act) begin
      cnt_d = cnt_q + 10'd1;
      if (cnt_q < 10'd44 && !(cnt_q >= 10'd40 && one)) begin
        hdr_d[cnt_q[5:0]] = data_byte_i;
      end
      if (in_val) begin
        vsh_d = {data_byte_i, vsh_q[31:8]};
      end
      if (done) begin
        elem_d = jlast ? 3'd0 : elem_q + 3'd1;
        joint_d = jlast ? joint_q + JW'(1) : joint_q;
      end
    end
  end

  // Header as it stands after this byte, for the summary.
  assign magic  = {hdr_d[3], hdr_d[2], hdr_d[1], hdr_d[0]};
  assign ver    = hdr_d[4];
  assign kind   = hdr_d[5];
  assign flag   = {hdr_d[7], hdr_d[6]};
  assign epoch  = {hdr_d[11], hdr_d[10], hdr_d[9], hdr_d[8]};
  assign space  = {hdr_d[15], hdr_d[14], hdr_d[13], hdr_d[12]};
  assign seq    = {hdr_d[19], hdr_d[18], hdr_d[17], hdr_d[16]};
  assign len_w  = {hdr_d[23], hdr_d[22], hdr_d[21], hdr_d[20]};
  assign obs    = {hdr_d[31], hdr_d[30], hdr_d[29], hdr_d[28],
                   hdr_d[27], hdr_d[26], hdr_d[25], hdr_d[24]};
  assign tgt    = {hdr_d[39], hdr_d[38], hdr_d[37], hdr_d[36],
                   hdr_d[35], hdr_d[34], hdr_d[33], hdr_d[32]};
  assign mask_w = {hdr_d[43], hdr_d[42], hdr_d[41], hdr_d[40]};
  assign expected = (kind == 8'd1) ? 11'(ShortLen) : LongLen;
  assign mask_s = (kind == 8'd1) ? 32'd0 : mask_w;

  assign bad_env = (magic != MagicWord) || (ver != 8'd1) || (kind < 8'd1) ||
                   (kind > 8'd3) || (flag > 16'd1) || ({1'b0, cnt_d} != expected) ||
                   (len_w != 32'(expected - 11'(HeaderLen))) ||
                   (obs[63:53] != 11'd0) || (tgt[63:53] != 11'd0);
  assign mask_err = ((mask_s & ~{7'd0, allowed_i}) != 32'd0) ||
                    ((kind != 8'd1) && ((mask_s != 32'd0) != (flag != 16'd0)));

  always_comb begin
    priority if (cnt_d < 10'(HeaderLen)) begin
      pre = StatusTrunc;
    end else if (bad_env) begin
      pre = StatusEnvelope;
    end else if (mask_err) begin
      pre = StatusMask;
    end else begin
      pre = StatusOk;
    end
  end

  always_comb begin
    entry_o.val     = done;
    entry_o.idx     = rel[9:2];
    entry_o.bits    = vsh_d;
    entry_o.sq      = (elem_q >= 3'd3) && (elem_q <= 3'd6);
    entry_o.jlast   = jlast;
    entry_o.tracked = one ? ({hdr_q[7], hdr_q[6]} != 16'd0)
                          : hdr_q[40 + 32'(joint_q[4:3])][joint_q[2:0]];
    entry_o.chk     = one || (joint_q < JointsLim);
    entry_o.stride8 = !one;
    entry_o.sum     = last_byte_i;
    entry_o.hdr.pre_status = pre;
    entry_o.hdr.kind   = kind;
    entry_o.hdr.pvalid = (flag != 16'd0);
    entry_o.hdr.epoch  = epoch;
    entry_o.hdr.space  = space;
    entry_o.hdr.seq    = seq;
    entry_o.hdr.obs    = obs[52:0];
    entry_o.hdr.tgt    = tgt[52:0];
    entry_o.hdr.mask   = mask_s[24:0];
  end

  assign push_o = accept_i && (done || last_byte_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      hdr_q   <= '0;
      vsh_q   <= '0;
      elem_q  <= '0;
      joint_q <= '0;
    end else if (accept_i) begin
      if (last_byte_i) begin
        cnt_q   <= '0;
        hdr_q   <= '0;
        vsh_q   <= '0;
        elem_q  <= '0;
        joint_q <= '0;
      end else begin
        cnt_q   <= cnt_d;
        hdr_q   <= hdr_d;
        vsh_q   <= vsh_d;
        elem_q  <= elem_d;
        joint_q <= joint_d;
      end
    end
  end

endmodule

// ===== src/pmv_fifo.sv =====
// Short queue of parsed entries between the parser and the checker.
module pmv_fifo import pmv_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t data_i,
  input  logic   pop_i,
  output entry_t head_o,
  output logic   full_o,
  output logic   empty_o
);

  localparam int unsigned Depth = 4;

  entry_t     mem_q [Depth];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;

  assign full_o  = (cnt_q == 3'(Depth));
  assign empty_o = (cnt_q == 3'd0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 2'd1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 2'd1;
      end
      cnt_q <= cnt_q + 3'(push_i) - 3'(pop_i);
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("queue read while empty");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> !empty_o) else $error("queue lost an entry");
`endif

endmodule

// ===== src/pmv_back.sv =====
// Joint checker: squares values, accumulates the norm and drives the result register.
module pmv_back import pmv_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  entry_t head_i,
  input  logic   empty_i,
  output logic   pop_o,
  input  logic   out_ready_i,
  output logic   out_valid_o,
  output out_t   out_o
);

  entry_t             ent_q;
  logic               v1_q;
  logic [47:0]        prod_q;
  logic signed [9:0]  sh_q;
  logic               inf_q;
  logic [62:0]        norm_q, norm_nx, norm_up, sqv;
  logic [1:0]         jfl_q, jfl_nx, jfl_up;
  logic [2:0]         fail_q, fail_nx, code;
  logic               out_valid_q, pend_q, out_free, adv;
  out_t               out_q, pend_rec_q, val_rec, sum_rec;

  logic [7:0]   e_raw, e_eff;
  logic [23:0]  man;
  logic [110:0] wide;
  logic [9:0]   shn;
  logic [63:0]  add;
  logic         negw;

  assign out_free = !out_valid_q || out_ready_i;
  assign adv = v1_q && out_free && !pend_q;
  assign pop_o = !empty_i && (!v1_q || adv);

  assign e_raw = head_i.bits[30:23];
  assign e_eff = (e_raw == 8'd0) ? 8'd1 : e_raw;
  assign man = {(e_raw != 8'd0), head_i.bits[22:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (pop_o) begin
      v1_q <= 1'b1;
    end else if (adv) begin
      v1_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ent_q  <= head_i;
      prod_q <= man * man;
      sh_q   <= $signed({2'b00, e_eff}) * 10'sd2 - 10'sd240;
      inf_q  <= (e_raw == ExpInf);
    end
  end

  // Square in 60 fraction bits, truncated, saturating.
  assign wide = {63'd0, prod_q} << sh_q[5:0];
  assign shn = 10'(-sh_q);
  always_comb begin
    if (inf_q) begin
      sqv = NormSat;
    end else if (sh_q >= 10'sd0) begin
      if (prod_q == 48'd0) begin
        sqv = '0;
      end else if (sh_q >= 10'sd63 || wide[110:63] != '0) begin
        sqv = NormSat;
      end else begin
        sqv = wide[62:0];
      end
    end else if (shn >= 10'd64) begin
      sqv = '0;
    end else begin
      sqv = 63'({15'd0, prod_q} >> shn[5:0]);
    end
  end

  assign add = {1'b0, norm_q} + {1'b0, sqv};
  assign norm_up = !ent_q.sq ? norm_q : (add[63] ? NormSat : add[62:0]);
  assign jfl_up = jfl_q | {(ent_q.bits[30:23] == ExpInf), (ent_q.bits[30:0] != 31'd0)};
  assign negw = ent_q.stride8 && ent_q.bits[31] && (ent_q.bits[30:0] != 31'd0);

  always_comb begin
    code = StatusOk;
    if (!ent_q.tracked) begin
      if (jfl_up[0]) begin
        code = StatusUntracked;
      end
    end else if (jfl_up[1] || norm_up < NormLow || norm_up > NormHigh || negw) begin
      code = StatusBadXform;
    end
  end

  always_comb begin
    norm_nx = norm_q;
    jfl_nx  = jfl_q;
    fail_nx = fail_q;
    if (ent_q.val && ent_q.chk) begin
      if (ent_q.jlast) begin
        norm_nx = '0;
        jfl_nx  = '0;
        if (fail_q == StatusOk) begin
          fail_nx = code;
        end
      end else begin
        norm_nx = norm_up;
        jfl_nx  = jfl_up;
      end
    end
  end

  always_comb begin
    val_rec = '0;
    val_rec.idx  = ent_q.idx;
    val_rec.bits = ent_q.bits;
    sum_rec = '0;
    sum_rec.is_sum = 1'b1;
    sum_rec.status = (ent_q.hdr.pre_status != StatusOk) ? ent_q.hdr.pre_status : fail_nx;
    sum_rec.kind   = ent_q.hdr.kind;
    sum_rec.pvalid = ent_q.hdr.pvalid;
    sum_rec.epoch  = ent_q.hdr.epoch;
    sum_rec.space  = ent_q.hdr.space;
    sum_rec.seq    = ent_q.hdr.seq;
    sum_rec.obs    = ent_q.hdr.obs;
    sum_rec.tgt    = ent_q.hdr.tgt;
    sum_rec.mask   = ent_q.hdr.mask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_q      <= '0;
      jfl_q       <= '0;
      fail_q      <= StatusOk;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      if (adv) begin
        if (ent_q.sum) begin
          norm_q <= '0;
          jfl_q  <= '0;
          fail_q <= StatusOk;
        end else begin
          norm_q <= norm_nx;
          jfl_q  <= jfl_nx;
          fail_q <= fail_nx;
        end
        pend_q <= ent_q.val && ent_q.sum;
      end else if (out_free) begin
        pend_q <= 1'b0;
      end
      if (out_free && (pend_q || adv)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && pend_q) begin
      out_q <= pend_rec_q;
    end else if (adv) begin
      out_q <= ent_q.val ? val_rec : sum_rec;
    end
    if (adv) begin
      pend_rec_q <= sum_rec;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o = out_q;

`ifndef SYNTH
  a_pend_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> out_valid_q) else $error("summary pending with no value shown");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.is_sum) |-> (out_q.status != 3'd6 && out_q.status != 3'd7))
    else $error("summary status out of range");
  a_value_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.is_sum) |-> (out_q.status == StatusOk && out_q.kind == 8'd0))
    else $error("value item carries summary fields");
`endif

endmodule

// ===== src/pose_message_validator.sv =====
// Top level of the pose message validator: config register, parser, queue and checker.
// The block takes one message byte per cycle with a last flag and keeps up with that
// rate as long as results are taken. A byte is parsed in the cycle it is accepted and,
// if it completes a float, enters the queue at that edge. From the queue the item
// moves into the squaring stage; from there it is added to the norm and loaded into
// the output register. A byte that both completes a value and is last yields two
// results, the value and then the summary, and holds the checker while the summary
// is pending. The four-entry queue absorbs that and short output stalls; a longer
// stall fills it and drops the input ready. Streamed values stay provisional until
// the summary that ends the message.
module pose_message_validator import pmv_pkg::*; #(
  parameter int unsigned JOINTS      = JointsDef,
  parameter int unsigned VALUE_COUNT = ValueCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        is_summary_o,
  output logic [7:0]  value_index_o,
  output logic [31:0] value_bits_o,
  output logic [2:0]  status_o,
  output logic [7:0]  pose_kind_o,
  output logic        pose_valid_o,
  output logic [31:0] epoch_o,
  output logic [31:0] space_epoch_o,
  output logic [31:0] sequence_res_o,
  output logic [52:0] observed_time_o,
  output logic [52:0] target_time_o,
  output logic [24:0] joint_mask_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [24:0] allowed_q;
  logic        accept, push, pop, full, empty;
  entry_t      entry, head;
  out_t        rec;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {7'd0, allowed_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allowed_q <= '1;
    end else if (psel && penable && pwrite) begin
      allowed_q <= pwdata[24:0];
    end
  end

  assign in_ready_o = !full;
  assign accept = in_valid_i && !full;

  pmv_front #(.JOINTS(JOINTS), .VALUE_COUNT(VALUE_COUNT)) u_front (
    .clk_i, .rst_ni,
    .accept_i(accept), .data_byte_i, .last_byte_i,
    .allowed_i(allowed_q),
    .push_o(push), .entry_o(entry)
  );

  pmv_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .data_i(entry), .pop_i(pop),
    .head_o(head), .full_o(full), .empty_o(empty)
  );

  pmv_back u_back (
    .clk_i, .rst_ni,
    .head_i(head), .empty_i(empty), .pop_o(pop),
    .out_ready_i, .out_valid_o, .out_o(rec)
  );

  assign is_summary_o    = rec.is_sum;
  assign value_index_o   = rec.idx;
  assign value_bits_o    = rec.bits;
  assign status_o        = rec.status;
  assign pose_kind_o     = rec.kind;
  assign pose_valid_o    = rec.pvalid;
  assign epoch_o         = rec.epoch;
  assign space_epoch_o   = rec.space;
  assign sequence_res_o  = rec.seq;
  assign observed_time_o = rec.obs;
  assign target_time_o   = rec.tgt;
  assign joint_mask_o    = rec.mask;

endmodule

// ===== tb/sv/pose_message_validator_tb.sv =====
// Testbench of the pose message validator: byte stimulus, a parsing predictor and a result checker.
`timescale 1ns / 100ps

module pose_message_validator_tb import pmv_pkg::*; ;

  localparam int unsigned NumJoints  = JointsDef;
  localparam int unsigned NumValues  = ValueCountDef;
  localparam int unsigned LongLen    = JointBase + 4 * NumValues;
  localparam logic [1:0]  AddrAllowMask = 2'd0;
  localparam int unsigned StallLimit = 5000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } msg_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b1;
  out_t        got;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pose_message_validator i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .data_byte_i, .last_byte_i,
    .out_valid_o, .out_ready_i,
    .is_summary_o(got.is_sum), .value_index_o(got.idx), .value_bits_o(got.bits),
    .status_o(got.status), .pose_kind_o(got.kind), .pose_valid_o(got.pvalid),
    .epoch_o(got.epoch), .space_epoch_o(got.space), .sequence_res_o(got.seq),
    .observed_time_o(got.obs), .target_time_o(got.tgt), .joint_mask_o(got.mask),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state, cleared after every summary.
  logic [24:0] allowed_mask;
  logic [9:0]  byte_cnt;
  logic [31:0] magic, epoch_w, space_w, seq_w, len_w, mask_w, float_shift;
  logic [7:0]  version, kind;
  logic [15:0] flags;
  logic [63:0] obs_w, tgt_w;
  logic [62:0] norm_acc;
  logic [2:0]  first_fail;
  logic [1:0]  seen_flags;

  out_t      result_q[$];
  msg_byte_t byte_q[$];
  int        errors = 0;
  bit        calm = 1'b0;

  function automatic void clear_msg();
    byte_cnt = '0; magic = '0; version = '0; kind = '0; flags = '0;
    epoch_w = '0; space_w = '0; seq_w = '0; len_w = '0; obs_w = '0; tgt_w = '0;
    mask_w = '0; float_shift = '0; norm_acc = '0; first_fail = '0; seen_flags = '0;
  endfunction

  // Square in unsigned fixed point with 60 fraction bits, truncated and saturating.
  function automatic logic [62:0] square_fx(input logic [31:0] b);
    int          e;
    int          sh;
    logic [63:0] m;
    logic [63:0] m2;
    e = b[30:23];
    m = {41'd0, b[22:0]};
    if (e == 255) return NormSat;
    if (e == 0) e = 1;
    else m[23] = 1'b1;
    m2 = m * m;
    sh = 2 * e - 240;
    if (sh >= 0) begin
      if (m2 == 0) return '0;
      if (sh >= 63 || m2 > ({1'b0, NormSat} >> sh)) return NormSat;
      return 63'(m2 << sh);
    end
    sh = -sh;
    if (sh >= 64) return '0;
    return 63'(m2 >> sh);
  endfunction

  function automatic void check_joint_value(input int unsigned idx, input logic [31:0] b);
    bit          one;
    int unsigned stride, joint, elem;
    bit          tracked;
    logic [2:0]  code;
    logic [62:0] sq;
    one = (kind == 8'd1);
    stride = one ? 7 : 8;
    joint = idx / stride;
    elem = idx % stride;
    code = StatusOk;
    if (!one && joint >= NumJoints) return;
    tracked = one ? (flags != 0) : mask_w[joint];
    if (b[30:0] != 0) seen_flags[0] = 1'b1;
    if (b[30:23] == ExpInf) seen_flags[1] = 1'b1;
    if (elem >= 3 && elem <= 6) begin
      sq = square_fx(b);
      norm_acc = (sq > NormSat - norm_acc) ? NormSat : norm_acc + sq;
    end
    if (elem != stride - 1) return;
    if (!tracked) begin
      if (seen_flags[0]) code = StatusUntracked;
    end else if (seen_flags[1] || norm_acc < NormLow || norm_acc > NormHigh ||
                 (stride == 8 && b[31] && b[30:0] != 0)) begin
      code = StatusBadXform;
    end
    if (first_fail == StatusOk) first_fail = code;
    seen_flags = '0;
    norm_acc = '0;
  endfunction

  function automatic void capture_header(input int unsigned p, input logic [7:0] b);
    if (p < 4) magic[8*p +: 8] = b;
    else if (p == 4) version = b;
    else if (p == 5) kind = b;
    else if (p < 8) flags[8*(p-6) +: 8] = b;
    else if (p < 12) epoch_w[8*(p-8) +: 8] = b;
    else if (p < 16) space_w[8*(p-12) +: 8] = b;
    else if (p < 20) seq_w[8*(p-16) +: 8] = b;
    else if (p < 24) len_w[8*(p-20) +: 8] = b;
    else if (p < 32) obs_w[8*(p-24) +: 8] = b;
    else if (p < 40) tgt_w[8*(p-32) +: 8] = b;
    else if (p < 44 && kind != 8'd1) mask_w[8*(p-40) +: 8] = b;
  endfunction

  function automatic logic [63:0] TimeMax();
    return (64'd1 << 53) - 1;
  endfunction

  // Advances the parser by one accepted byte and queues the results it causes.
  function automatic void parse_byte(input logic [7:0] b, input logic last);
    int unsigned p, off, nval, expected_len;
    bit          one;
    logic [31:0] msk;
    out_t        r;
    p = 32'(byte_cnt);
    if (p < CountMax) begin
      one = (kind == 8'd1);
      off = one ? HeaderLen : JointBase;
      nval = one ? 7 : NumValues;
      byte_cnt = 10'(p + 1);
      capture_header(p, b);
      if (p >= off && p < off + 4 * nval) begin
        float_shift = {b, float_shift[31:8]};
        if (((p - off) & 3) == 3) begin
          r = '0;
          r.idx = 8'((p - off) >> 2);
          r.bits = float_shift;
          result_q.insert(result_q.size(), r);
          check_joint_value((p - off) >> 2, float_shift);
        end
      end
    end
    if (last) begin
      one = (kind == 8'd1);
      expected_len = one ? ShortLen : LongLen;
      msk = one ? '0 : mask_w;
      r = '0;
      r.is_sum = 1'b1;
      if (byte_cnt < HeaderLen) r.status = StatusTrunc;
      else if (magic != MagicWord || version != 8'd1 || kind < 8'd1 || kind > 8'd3 ||
               flags > 16'd1 || byte_cnt != expected_len ||
               len_w != expected_len - HeaderLen ||
               obs_w > TimeMax() || tgt_w > TimeMax())
        r.status = StatusEnvelope;
      else if ((msk & ~{7'd0, allowed_mask}) != 0 || (!one && ((msk != 0) != (flags != 0))))
        r.status = StatusMask;
      else r.status = first_fail;
      r.kind = kind;
      r.pvalid = (flags != 0);
      r.epoch = epoch_w;
      r.space = space_w;
      r.seq = seq_w;
      r.obs = obs_w[52:0];
      r.tgt = tgt_w[52:0];
      r.mask = msk[24:0];
      result_q.insert(result_q.size(), r);
      clear_msg();
    end
  endfunction

  // Stimulus helpers.
  function automatic logic [31:0] pick_float(input int unsigned elem, input bit tracked,
                                             input bit well_formed, input bit stride8);
    logic [31:0] v;
    if (!tracked && well_formed) return (($urandom_range(0, 3) == 0) ? 32'h8000_0000 : '0);
    if (well_formed) begin
      if (elem >= 3 && elem <= 6) begin
        v = 32'h3F00_0000;
        if (elem != 6 && $urandom_range(0, 1)) v[31] = 1'b1;
        return v;
      end
      return stride8 && elem == 7 ? 32'h3F80_0000 : $urandom;
    end
    case ($urandom_range(0, 8))
      0: v = '0;
      1: v = 32'h8000_0000;
      2: v = 32'hBF00_0000;
      3: v = 32'h3F80_0000;
      4: v = {1'($urandom_range(0, 1)), 8'hFF, 23'd0};
      5: v = {1'($urandom_range(0, 1)), 8'hFF, 23'($urandom | 1)};
      6: v = {1'($urandom_range(0, 1)), 8'd0, 23'($urandom)};
      7: v = 32'h3F00_0000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic void push_word(ref logic [7:0] m[$], input logic [63:0] w, input int n);
    for (int i = 0; i < n; i++) m.insert(m.size(), w[8*i +: 8]);
  endfunction

  function automatic void add_byte(input logic [7:0] d, input logic l);
    msg_byte_t e;
    e.data = d;
    e.last = l;
    byte_q.insert(byte_q.size(), e);
  endfunction

  // Builds one message; flaw 0 clean, 1 corrupt byte, 2 cut short near the start,
  // 3 extra bytes, 4 padded past the byte count limit.
  task automatic queue_message(input logic [7:0] k, input int flaw);
    logic [7:0]  m[$];
    logic [31:0] jmask;
    logic [15:0] fl;
    bit          good;
    int          nval, stride, cut;
    good = ($urandom_range(0, 4) != 0);
    case ($urandom_range(0, 3))
      0: jmask = '0;
      1: jmask = 32'h01FF_FFFF;
      default: jmask = {7'd0, 25'($urandom)};
    endcase
    fl = (k == 8'd1) ? 16'($urandom_range(0, 1)) : 16'(jmask != 0);
    if ($urandom_range(0, 9) == 0) fl = 16'($urandom);
    nval = (k == 8'd1) ? 7 : NumValues;
    stride = (k == 8'd1) ? 7 : 8;
    push_word(m, MagicWord, 4);
    m.insert(m.size(), 8'd1);
    m.insert(m.size(), k);
    push_word(m, fl, 2);
    push_word(m, $urandom, 4);
    push_word(m, $urandom, 4);
    push_word(m, $urandom, 4);
    push_word(m, (k == 8'd1) ? ShortLen - HeaderLen : LongLen - HeaderLen, 4);
    push_word(m, ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                             : {11'd0, 21'($urandom), 32'($urandom)}, 8);
    push_word(m, ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                             : {11'd0, 21'($urandom), 32'($urandom)}, 8);
    if (k != 8'd1) push_word(m, jmask, 4);
    for (int i = 0; i < nval; i++)
      push_word(m, pick_float(i % stride, (k == 8'd1) ? fl != 0 : jmask[i / stride], good,
                              stride == 8), 4);
    case (flaw)
      1: m[$urandom_range(0, m.size() - 1)] = 8'($urandom);
      2: begin
        cut = $urandom_range(1, ((m.size() < 100) ? m.size() : 100) - 1);
        while (m.size() > cut) void'(m.pop_back());
      end
      3: repeat ($urandom_range(1, 6)) m.insert(m.size(), 8'($urandom));
      4: while (m.size() < 1030) m.insert(m.size(), 8'($urandom));
      default: ;
    endcase
    foreach (m[i]) add_byte(m[i], i == m.size() - 1);
  endtask

  task automatic queue_noise(input int n);
    for (int i = 0; i < n; i++)
      add_byte(8'($urandom), (i == n - 1) || ($urandom_range(0, 15) == 0));
  endtask

  task automatic write_allowed_mask(input logic [24:0] v);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= AddrAllowMask;
    pwdata <= {7'd0, v};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    allowed_mask = v;
  endtask

  task automatic drain();
    while (byte_q.size() != 0 || in_valid_i || result_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Input driver: bytes leave the queue at the falling edge, with random gaps.
  bit in_fire = 1'b0;
  int in_gap = 0;
  always @(posedge clk_i) in_fire <= in_valid_i && in_ready_o;

  always @(negedge clk_i) begin
    if (!in_valid_i || in_fire) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (byte_q.size() > 0 && rst_ni) begin
        {data_byte_i, last_byte_i} <= byte_q[0];
        byte_q.delete(0);
        in_valid_i <= 1'b1;
        if (!calm && $urandom_range(0, 11) == 0) in_gap <= $urandom_range(1, 10);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  int out_stall = 0;
  always @(negedge clk_i) begin
    if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (!calm && $urandom_range(0, 11) == 0) out_stall <= $urandom_range(1, 10);
    end
  end

  // Predictor runs on each accepted byte; the checker on each accepted result.
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    out_t want;
    if (in_valid_i && in_ready_o) parse_byte(data_byte_i, last_byte_i);
    if (out_valid_o && out_ready_i) begin
      if (result_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
      end else begin
        want = result_q[0];
        result_q.delete(0);
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch\n  expected %p\n  actual   %p", want, got);
        end
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("FAIL pose_message_validator");
      $finish;
    end
  end

  initial begin
    allowed_mask = 25'h1FF_FFFF;
    clear_msg();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_allowed_mask(25'h1FF_FFFF);
    // Directed: lone last byte, a short header, an unflawed kind 1 message, an unknown kind.
    queue_noise(1);
    add_byte(8'h43, 1'b0);
    add_byte(8'hFF, 1'b1);
    queue_message(8'd1, 0);
    queue_message(8'd7, 2);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_allowed_mask('0);
        1: write_allowed_mask(25'($urandom));
        2: write_allowed_mask(25'h1FF_FFFF);
        default: begin
          write_allowed_mask(25'h1FF_FFFF);
          calm = 1'b1;
        end
      endcase
      if (phase == 2) queue_message(($urandom_range(0, 1) != 0) ? 8'd2 : 8'd3, 0);
      for (int i = 0; i < 2; i++) begin
        queue_message(8'd1, ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
        if ($urandom_range(0, 2) == 0) queue_noise($urandom_range(1, 20));
      end
      drain();
    end

    if (errors == 0) $display("PASS pose_message_validator");
    else $display("FAIL pose_message_validator");
    $finish;
  end

endmodule
